/* rtl/core/trie_word_count_table_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the trie word count table
// Shorthand for clocked assertions that are disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef TRIE_WORD_COUNT_TABLE_MACROS_SVH
`define TRIE_WORD_COUNT_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TWCT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TWCT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/twct_pkg.sv */
// ----------------------------------------------------------------------------
// twct_pkg
// Sizes, codes, command and status structs and the character decoder that
// the trie word count table modules share.
// ----------------------------------------------------------------------------
package twct_pkg;

    localparam int NODE_POOL  = 4096;
    localparam int ALPHABET   = 52;
    localparam int NODE_AW    = $clog2(NODE_POOL);
    localparam int NODE_CW    = $clog2(NODE_POOL + 1);
    localparam int SLOT_W     = $clog2(ALPHABET);
    localparam int LINK_DEPTH = NODE_POOL * ALPHABET;
    localparam int LINK_AW    = $clog2(LINK_DEPTH);
    localparam int KEY_W      = NODE_AW + SLOT_W;
    localparam int COUNT_W    = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [7:0] CHAR_UC_A = 8'h41;
    localparam logic [7:0] CHAR_UC_Z = 8'h5A;
    localparam logic [7:0] CHAR_LC_A = 8'h61;
    localparam logic [7:0] CHAR_LC_Z = 8'h7A;
    localparam logic [SLOT_W-1:0] LC_SLOT_BASE = SLOT_W'(26);

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        COND_NONE    = 2'd0,
        COND_FULL    = 2'd1,
        COND_INVALID = 2'd2,
        COND_MISS    = 2'd3
    } t_cond;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic sweep;
        logic load;
        logic clear;
        logic link_rd;
        logic key_rd;
        logic resolve;
        logic set_invalid;
        logic count_rd;
        logic finish;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sweep_last;
        logic walk;
        logic slot_ok;
        logic word_end;
        logic cond_none;
    } t_dp_stat;

    // Maps a byte to its child slot; the top bit flags a letter.
    function automatic logic [SLOT_W:0] slot_of(input logic [7:0] ch);
        logic [SLOT_W:0] res;
        res = '0;
        if (ch >= CHAR_UC_A && ch <= CHAR_UC_Z) begin
            res = {1'b1, SLOT_W'(ch - CHAR_UC_A)};
        end else if (ch >= CHAR_LC_A && ch <= CHAR_LC_Z) begin
            res = {1'b1, SLOT_W'(ch - CHAR_LC_A) + LC_SLOT_BASE};
        end
        return res;
    endfunction

endpackage

/* rtl/core/twct_ram.sv */
// ----------------------------------------------------------------------------
// twct_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module twct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/twct_ctrl.sv */
// ----------------------------------------------------------------------------
// twct_ctrl
// Sequencer for the trie word count table: sweeps the child table, takes
// words and clears, steps the datapath through child lookup and end count.
// ----------------------------------------------------------------------------
module twct_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [1:0]         i_cmd,
    input  twct_pkg::t_dp_stat i_stat,
    output twct_pkg::t_dp_cmd  o_cmd,
    output logic               o_busy
);

    import twct_pkg::*;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_STEP,
        S_LINK,
        S_CHECK,
        S_END,
        S_COUNT
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_busy;
    t_dp_cmd n_cmd;

    always_comb begin
        n_state = r_state;
        n_cmd   = '0;
        case (r_state)
            S_INIT: begin
                // Zero the whole child table once, then clear the root.
                n_cmd.sweep = 1'b1;
                if (i_stat.sweep_last) begin
                    n_cmd.clear = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_CLEAR: begin
                n_cmd.clear = 1'b1;
                n_state     = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    n_cmd.load = 1'b1;
                    case (t_cmd'(i_cmd))
                        CMD_CLEAR:              n_state = S_CLEAR;
                        CMD_INSERT, CMD_SEARCH: n_state = S_STEP;
                        default:                n_state = S_IDLE;
                    endcase
                end
            end
            S_STEP: begin
                if (i_stat.walk && i_stat.slot_ok) begin
                    n_cmd.link_rd = 1'b1;
                    n_state       = S_LINK;
                end else begin
                    n_cmd.set_invalid = i_stat.walk;
                    n_state           = S_END;
                end
            end
            S_LINK: begin
                n_cmd.key_rd = 1'b1;
                n_state      = S_CHECK;
            end
            S_CHECK: begin
                n_cmd.resolve = 1'b1;
                n_state       = S_END;
            end
            S_END: begin
                if (!i_stat.word_end) begin
                    n_state = S_IDLE;
                end else if (i_stat.cond_none) begin
                    n_cmd.count_rd = 1'b1;
                    n_state        = S_COUNT;
                end else begin
                    n_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_COUNT: begin
                n_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_busy  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_cmd  = n_cmd;
    assign o_busy = r_busy;

endmodule

/* rtl/core/twct_dp.sv */
// ----------------------------------------------------------------------------
// twct_dp
// Datapath of the trie word count table: item registers, walk state, the
// child, owner and end count memories, and the result register.
// ----------------------------------------------------------------------------
module twct_dp (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  twct_pkg::t_dp_cmd        i_cmd,
    input  logic [1:0]               i_item_cmd,
    input  logic [7:0]               i_char_code,
    input  logic                     i_char_present,
    input  logic                     i_word_end,
    output twct_pkg::t_dp_stat       o_stat,
    output logic                     o_valid,
    output logic [twct_pkg::COUNT_W-1:0] o_word_count,
    output logic [1:0]               o_status
);

    import twct_pkg::*;

    // Item registers.
    t_cmd        r_cmd;
    logic [7:0]  r_char;
    logic        r_present;
    logic        r_end;

    // Walk state.
    logic [NODE_AW-1:0] r_node;
    logic [NODE_CW-1:0] r_used;
    t_cond              r_cond;

    // Address of the child table entry zeroed by the sweep after reset.
    logic [LINK_AW-1:0] r_sweep;

    // Result register.
    logic               r_valid;
    logic [COUNT_W-1:0] r_count;
    t_status            r_status;

    logic [SLOT_W:0]    slot_dec;
    logic [SLOT_W-1:0]  slot;
    logic [LINK_AW-1:0] link_addr;
    logic [NODE_CW-1:0] link_q;
    logic               link_we;
    logic [LINK_AW-1:0] link_waddr;
    logic [NODE_CW-1:0] link_wdata;
    logic [KEY_W-1:0]   key_q;
    logic [KEY_W-1:0]   key_here;
    logic [COUNT_W-1:0] count_q;
    logic [COUNT_W-1:0] count_next;
    logic               hit;
    logic               pool_full;
    logic               alloc;
    logic               count_up;
    logic               count_we;
    logic [NODE_AW-1:0] count_waddr;
    logic [COUNT_W-1:0] count_wdata;

    assign slot_dec  = slot_of(r_char);
    assign slot      = slot_dec[SLOT_W-1:0];
    assign key_here  = {r_node, slot};
    assign link_addr = LINK_AW'(r_node) * LINK_AW'(ALPHABET) + LINK_AW'(slot);

    // A stored link is trusted only if it names a node of the current
    // allocation epoch whose owner record points back at this row and slot.
    assign hit = (link_q != '0) && (link_q < r_used) && (key_q == key_here);
    assign pool_full = (r_used == NODE_CW'(NODE_POOL));
    assign alloc = i_cmd.resolve && !hit && (r_cmd == CMD_INSERT) && !pool_full;

    assign link_we    = alloc || i_cmd.sweep;
    assign link_waddr = i_cmd.sweep ? r_sweep : link_addr;
    assign link_wdata = i_cmd.sweep ? '0 : r_used;

    assign count_next = (r_cmd == CMD_INSERT && count_q != COUNT_MAX)
                      ? count_q + COUNT_W'(1) : count_q;
    assign count_up   = i_cmd.finish && (r_cond == COND_NONE) && (r_cmd == CMD_INSERT);

    always_comb begin
        count_we    = 1'b0;
        count_waddr = r_node;
        count_wdata = '0;
        if (i_cmd.clear) begin
            count_we    = 1'b1;
            count_waddr = '0;
        end else if (alloc) begin
            count_we    = 1'b1;
            count_waddr = r_used[NODE_AW-1:0];
        end else if (count_up) begin
            count_we    = 1'b1;
            count_wdata = count_next;
        end
    end

    twct_ram #(
        .WIDTH (NODE_CW),
        .DEPTH (LINK_DEPTH)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_re    (i_cmd.link_rd),
        .i_raddr (link_addr),
        .o_rdata (link_q)
    );

    twct_ram #(
        .WIDTH (KEY_W),
        .DEPTH (NODE_POOL)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (alloc),
        .i_waddr (r_used[NODE_AW-1:0]),
        .i_wdata (key_here),
        .i_re    (i_cmd.key_rd),
        .i_raddr (link_q[NODE_AW-1:0]),
        .o_rdata (key_q)
    );

    twct_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (NODE_POOL)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (count_we),
        .i_waddr (count_waddr),
        .i_wdata (count_wdata),
        .i_re    (i_cmd.count_rd),
        .i_raddr (r_node),
        .o_rdata (count_q)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd     <= t_cmd'(i_item_cmd);
            r_char    <= i_char_code;
            r_present <= i_char_present;
            r_end     <= i_word_end;
        end
        if (i_cmd.finish) begin
            if (r_cond == COND_NONE) begin
                r_count  <= count_next;
                r_status <= ST_OK;
            end else begin
                r_count <= '0;
                case (r_cond)
                    COND_FULL:    r_status <= ST_FULL;
                    COND_INVALID: r_status <= ST_INVALID;
                    default:      r_status <= ST_OK;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node  <= '0;
            r_used  <= NODE_CW'(1);
            r_cond  <= COND_NONE;
            r_valid <= 1'b0;
            r_sweep <= '0;
        end else begin
            r_valid <= i_cmd.finish;
            if (i_cmd.sweep) begin
                r_sweep <= r_sweep + LINK_AW'(1);
            end
            if (i_cmd.clear) begin
                r_node <= '0;
                r_used <= NODE_CW'(1);
                r_cond <= COND_NONE;
            end else if (i_cmd.set_invalid) begin
                r_cond <= COND_INVALID;
            end else if (i_cmd.resolve) begin
                if (hit) begin
                    r_node <= link_q[NODE_AW-1:0];
                end else if (r_cmd != CMD_INSERT) begin
                    r_cond <= COND_MISS;
                end else if (pool_full) begin
                    r_cond <= COND_FULL;
                end else begin
                    r_node <= r_used[NODE_AW-1:0];
                    r_used <= r_used + NODE_CW'(1);
                end
            end else if (i_cmd.finish) begin
                r_node <= '0;
                r_cond <= COND_NONE;
            end
        end
    end

    assign o_stat.sweep_last = (r_sweep == LINK_AW'(LINK_DEPTH - 1));
    assign o_stat.walk       = r_present && (r_cond == COND_NONE);
    assign o_stat.slot_ok    = slot_dec[SLOT_W];
    assign o_stat.word_end   = r_end;
    assign o_stat.cond_none  = (r_cond == COND_NONE);

    assign o_valid      = r_valid;
    assign o_word_count = r_count;
    assign o_status     = r_status;

endmodule

/* rtl/core/trie_word_count_table.sv */
// ----------------------------------------------------------------------------
// trie_word_count_table
// Counts words in a trie held in on-chip memory; words arrive one character
// per command and the last character returns the word's count.
// ----------------------------------------------------------------------------
// A command is accepted when start is high and busy is low. Each command
// carries one character of a text word and an end mark; an insert or search
// command with the end mark set produces exactly one result, shown on
// o_word_count and o_status for a single cycle while o_valid is high. The
// receiver cannot stall the block, so results must be captured when o_valid
// is seen. A character that is walked passes through a child table read and
// then the owner table read that checks it; the two are dependent synchronous
// reads. The end of a word that is counted or looked up adds an end count
// read before o_valid rises. A command with no character, one with an invalid
// byte, or one issued after the walk already failed skips both table reads,
// as does a clear, and command code three is taken with no effect while busy
// stays low. After reset, busy stays high while all 212992 child table
// entries are zeroed in turn and the root's end count is written. A clear does
// not sweep the child table again. Instead each allocated node records its
// parent and slot, and a child link counts only when it names a node
// allocated since the last clear whose record points back, so stale links
// from earlier trees are ignored. Letters A to Z and a to z are accepted; any
// other byte marks the word invalid. A full node pool marks the word and
// leaves it uncounted.
// ----------------------------------------------------------------------------
module trie_word_count_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_char_code,
    input  logic        i_char_present,
    input  logic        i_word_end,
    output logic        o_valid,
    output logic [15:0] o_word_count,
    output logic [1:0]  o_status
);

    import twct_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // The sequencer steps through lookup, allocation and count update.
    twct_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_cmd),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .o_busy  (busy)
    );

    // The datapath owns the memories, the walk registers and the result.
    twct_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .i_item_cmd     (i_cmd),
        .i_char_code    (i_char_code),
        .i_char_present (i_char_present),
        .i_word_end     (i_word_end),
        .o_stat         (dp_stat),
        .o_valid        (o_valid),
        .o_word_count   (o_word_count),
        .o_status       (o_status)
    );

    // A failed word always reports a zero count.
    `include "trie_word_count_table_macros.svh"

    `TWCT_ASSERT_SAME(a_fail_zero_count, o_valid, (o_status == ST_OK || o_word_count == '0), "failed word reported a nonzero count")

    // Results only come out of work that was in progress.
    `TWCT_ASSERT_SAME(a_valid_after_busy, o_valid, $past(busy), "result strobe without work in progress")

    // Two results never come out back to back.
    `TWCT_ASSERT_NEXT(a_valid_single, o_valid, !o_valid, "result strobe held for two cycles")

    // A real command keeps the block busy in the following cycle.
    `TWCT_ASSERT_NEXT(a_busy_on_accept, (start && !busy && i_cmd != CMD_NONE), busy, "accepted command left the block idle")

endmodule
